// ===== src/tfq_pkg.sv =====
// ----------------------------------------------------------------------------
// tfq_pkg: shared types and constants of the three-level feedback scheduler
// Command and result item layouts, operation codes, event codes, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package tfq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_Q1 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_Q2 = 1'b1;

    localparam logic [7:0] Q1_RESET = 8'd2;
    localparam logic [7:0] Q2_RESET = 8'd4;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] EV_IDLE     = 3'd0;
    localparam logic [2:0] EV_RAN      = 3'd1;
    localparam logic [2:0] EV_FINISHED = 3'd2;
    localparam logic [2:0] EV_DEMOTED  = 3'd3;
    localparam logic [2:0] EV_REQUEUED = 3'd4;
    localparam logic [2:0] EV_PROMOTED = 3'd5;

    localparam logic [1:0] LVL1 = 2'd1;
    localparam logic [1:0] LVL2 = 2'd2;
    localparam logic [1:0] LVL3 = 2'd3;

    // pre-emption counter runs 0,1,2 and wraps; the wrap promotes
    localparam logic [1:0] PREEMPT_LAST = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  task_id;
        logic [15:0] burst_length;
        logic        keep_leftover;
    } tfq_in_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [3:0]  event_task;
        logic [1:0]  event_level;
        logic [31:0] tick_time;
        logic        last_of_tick;
    } tfq_out_t;

endpackage

// ===== src/tfq_ram.sv =====
// ----------------------------------------------------------------------------
// tfq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns the
// old contents when the same address is written in that cycle.
// ----------------------------------------------------------------------------
module tfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/three_level_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler: three-level feedback-queue scheduler
// Arrive commands queue a task at level 1; tick commands run one time unit
// with demotion, pre-emption and promotion between the three FIFO levels.
// ----------------------------------------------------------------------------
//
//  channel   signals                       handshake
//  --------  ----------------------------  -----------------------------------
//  command   cmd (tfq_in_t)                start high while busy low
//  result    result (tfq_out_t)            result_strobe, one cycle per item
//  config    wr_index, wr_data             wr_en, no wait
//
// An arrive gives no result. A tick gives its result in the cycle after it
// is taken. A tick that pre-empts gives two results in consecutive cycles
// and holds busy high while the second result is worked out (the level FIFO
// head read is the only shared path).
// Reset clears counters, pointers and task presence bits at once; the FIFO
// RAMs need no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module three_level_feedback_queue_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tfq_pkg::tfq_in_t                 cmd,
    output logic                             result_strobe,
    output tfq_pkg::tfq_out_t                result,
    input  logic                             wr_en,
    input  logic [tfq_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [tfq_pkg::CFG_DATA_W-1:0]   wr_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN2 = 1'b1;

    typedef struct packed {
        logic [3:0]            tid;
        logic [BURST_BITS-1:0] rem;
        logic                  keep;
        logic [1:0]            mod3;
        logic [7:0]            saved;
    } fifo_entry_t;

    localparam int ENTRY_W = $bits(fifo_entry_t);

    function automatic logic [7:0] quantum_of(input logic [1:0] lvl,
                                              input logic [7:0] qa,
                                              input logic [7:0] qb);
        logic [7:0] q;
        case (lvl)
            tfq_pkg::LVL1: q = (qa == 8'd0) ? 8'd1 : qa;
            tfq_pkg::LVL2: q = (qb == 8'd0) ? 8'd1 : qb;
            default:       q = 8'd0;
        endcase
        return q;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [7:0] q1_reg, q1_next;
    logic [7:0] q2_reg, q2_next;

    // FIFO bookkeeping, one per level
    logic [IDX_W-1:0] head_reg [3];
    logic [IDX_W-1:0] head_next [3];
    logic [IDX_W-1:0] tail_reg [3];
    logic [IDX_W-1:0] tail_next [3];
    logic [CNT_W-1:0] count_reg [3];
    logic [CNT_W-1:0] count_next [3];
    logic [2:0]       bypass_sel_reg, bypass_sel_next;
    fifo_entry_t      bypass_data_reg [3];
    logic [ENTRY_W-1:0] rdata_raw [3];
    fifo_entry_t      head_data [3];
    logic [2:0]       push_ok;

    // running task
    logic                  run_valid_reg, run_valid_next;
    logic [3:0]            run_task_reg, run_task_next;
    logic [1:0]            run_level_reg, run_level_next;
    logic [7:0]            slice_reg, slice_next;
    logic [BURST_BITS-1:0] run_rem_reg, run_rem_next;
    logic                  run_keep_reg, run_keep_next;
    logic [1:0]            run_mod3_reg, run_mod3_next;
    logic [IDX_W-1:0]      run_idx;

    logic [31:0]          time_reg, time_next;
    logic [MAX_TASKS-1:0] present_reg, present_next;
    logic                 state_reg, state_next;

    tfq_pkg::tfq_out_t result_reg, result_next;
    logic              result_strobe_reg, result_strobe_next;

    // per-cycle control
    logic                  accept;
    logic                  preempt;
    logic                  do_run;
    logic                  push_en;
    logic [1:0]            push_lvl;
    fifo_entry_t           push_entry;
    logic                  pop_en;
    logic [1:0]            pop_lvl;
    logic                  any_ready;
    logic [1:0]            sel_lvl;
    logic                  arr_ok;
    logic [IDX_W-1:0]      arr_idx;
    logic [BURST_BITS-1:0] burst_ext;
    logic [1:0]            mod3_inc;

    // candidate for this run step
    fifo_entry_t           sel_entry;
    logic [3:0]            cur_task;
    logic [1:0]            cand_level;
    logic [7:0]            cur_slice;
    logic [BURST_BITS-1:0] cur_rem;
    logic                  cur_keep;
    logic [1:0]            cur_mod3;
    logic [BURST_BITS-1:0] rem_dec;
    logic [7:0]            slice_dec;
    logic [IDX_W-1:0]      cur_idx;

    assign busy          = (state_reg == ST_RUN2);
    assign accept        = start && !busy;
    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;
    assign run_idx       = IDX_W'(run_task_reg);

    assign burst_ext = BURST_BITS'(cmd.burst_length);
    assign arr_idx   = IDX_W'(cmd.task_id);
    assign arr_ok    = (32'(cmd.task_id) < MAX_TASKS) && (burst_ext != '0)
                       && !present_reg[arr_idx];

    assign preempt   = run_valid_reg && (run_level_reg != tfq_pkg::LVL1)
                       && (count_reg[0] != '0);
    assign mod3_inc  = (run_mod3_reg == tfq_pkg::PREEMPT_LAST) ? 2'd0
                                                                : run_mod3_reg + 2'd1;

    for (genvar g = 0; g < 3; g++)
    begin : g_lvl
        tfq_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (MAX_TASKS)
        ) u_ram (
            .clk   (clk),
            .we    (push_ok[g]),
            .waddr (tail_reg[g]),
            .wdata (push_entry),
            .raddr (head_next[g]),
            .rdata (rdata_raw[g])
        );
        // a push that lands on the next head is forwarded past the RAM
        assign head_data[g] = bypass_sel_reg[g] ? bypass_data_reg[g]
                                                : fifo_entry_t'(rdata_raw[g]);
    end

    // highest non-empty level and the task that would run
    always_comb
    begin
        any_ready = (count_reg[0] != '0) || (count_reg[1] != '0) || (count_reg[2] != '0);
        if (count_reg[0] != '0)
        begin
            sel_lvl = 2'd0;
        end
        else if (count_reg[1] != '0)
        begin
            sel_lvl = 2'd1;
        end
        else
        begin
            sel_lvl = 2'd2;
        end

        case (sel_lvl)
            2'd0:    sel_entry = head_data[0];
            2'd1:    sel_entry = head_data[1];
            default: sel_entry = head_data[2];
        endcase

        if (run_valid_reg)
        begin
            cur_task   = run_task_reg;
            cand_level = run_level_reg;
            cur_slice  = slice_reg;
            cur_rem    = run_rem_reg;
            cur_keep   = run_keep_reg;
            cur_mod3   = run_mod3_reg;
        end
        else
        begin
            cur_task   = sel_entry.tid;
            cand_level = sel_lvl + 2'd1;
            cur_slice  = sel_entry.keep ? sel_entry.saved
                                        : quantum_of(cand_level, q1_reg, q2_reg);
            if (cur_slice == 8'd0 && cand_level != tfq_pkg::LVL3)
            begin
                cur_slice = 8'd1;
            end
            cur_rem   = sel_entry.rem;
            cur_keep  = sel_entry.keep;
            cur_mod3  = sel_entry.mod3;
        end
        rem_dec   = cur_rem - BURST_BITS'(1);
        slice_dec = cur_slice - 8'd1;
        cur_idx   = IDX_W'(cur_task);
    end

    always_comb
    begin
        q1_next            = q1_reg;
        q2_next            = q2_reg;
        run_valid_next     = run_valid_reg;
        run_task_next      = run_task_reg;
        run_level_next     = run_level_reg;
        slice_next         = slice_reg;
        run_rem_next       = run_rem_reg;
        run_keep_next      = run_keep_reg;
        run_mod3_next      = run_mod3_reg;
        time_next          = time_reg;
        present_next       = present_reg;
        state_next         = state_reg;
        result_next        = result_reg;
        result_strobe_next = 1'b0;
        push_en            = 1'b0;
        push_lvl           = 2'd0;
        push_entry         = '0;
        pop_en             = 1'b0;
        pop_lvl            = 2'd0;
        do_run             = 1'b0;

        if (wr_en)
        begin
            case (wr_index)
                tfq_pkg::REG_Q1: q1_next = wr_data;
                tfq_pkg::REG_Q2: q2_next = wr_data;
                default:         ;
            endcase
        end

        if (accept && cmd.opcode == tfq_pkg::OP_ARRIVE)
        begin
            if (arr_ok)
            begin
                present_next[arr_idx] = 1'b1;
                push_en    = 1'b1;
                push_lvl   = 2'd0;
                push_entry = '{tid: cmd.task_id, rem: burst_ext, keep: cmd.keep_leftover,
                               mod3: 2'd0,
                               saved: quantum_of(tfq_pkg::LVL1, q1_reg, q2_reg)};
            end
        end
        else if (accept)
        begin
            time_next = time_reg + 32'd1;
            if (preempt)
            begin
                push_en    = 1'b1;
                push_entry = '{tid: run_task_reg, rem: run_rem_reg, keep: run_keep_reg,
                               mod3: mod3_inc, saved: 8'd0};
                result_next.event_task   = run_task_reg;
                result_next.tick_time    = time_next;
                result_next.last_of_tick = 1'b0;
                if (mod3_inc == 2'd0)
                begin
                    push_lvl = run_level_reg - 2'd2;
                    push_entry.saved = quantum_of(run_level_reg - 2'd1, q1_reg, q2_reg);
                    result_next.event_code  = tfq_pkg::EV_PROMOTED;
                    result_next.event_level = run_level_reg - 2'd1;
                end
                else
                begin
                    push_lvl = run_level_reg - 2'd1;
                    push_entry.saved = run_keep_reg ? slice_reg
                                                    : quantum_of(run_level_reg, q1_reg, q2_reg);
                    result_next.event_code  = tfq_pkg::EV_REQUEUED;
                    result_next.event_level = run_level_reg;
                end
                result_strobe_next = 1'b1;
                run_valid_next     = 1'b0;
                state_next         = ST_RUN2;
            end
            else
            begin
                do_run = 1'b1;
            end
        end

        if (state_reg == ST_RUN2)
        begin
            do_run     = 1'b1;
            state_next = ST_IDLE;
        end

        if (do_run)
        begin
            result_strobe_next       = 1'b1;
            result_next.tick_time    = time_next;
            result_next.last_of_tick = 1'b1;
            if (!run_valid_reg && !any_ready)
            begin
                result_next.event_code  = tfq_pkg::EV_IDLE;
                result_next.event_task  = 4'd0;
                result_next.event_level = tfq_pkg::LVL1;
            end
            else
            begin
                if (!run_valid_reg)
                begin
                    pop_en  = 1'b1;
                    pop_lvl = sel_lvl;
                end
                run_valid_next = 1'b1;
                run_task_next  = cur_task;
                run_level_next = cand_level;
                run_keep_next  = cur_keep;
                run_mod3_next  = cur_mod3;
                run_rem_next   = rem_dec;
                slice_next     = cur_slice;
                result_next.event_task  = cur_task;
                result_next.event_level = cand_level;
                result_next.event_code  = tfq_pkg::EV_RAN;
                if (rem_dec == '0)
                begin
                    run_valid_next         = 1'b0;
                    present_next[cur_idx]  = 1'b0;
                    result_next.event_code = tfq_pkg::EV_FINISHED;
                end
                else if (cand_level != tfq_pkg::LVL3)
                begin
                    slice_next = slice_dec;
                    if (slice_dec == 8'd0)
                    begin
                        push_en    = 1'b1;
                        push_lvl   = cand_level;
                        push_entry = '{tid: cur_task, rem: rem_dec, keep: cur_keep,
                                       mod3: cur_mod3,
                                       saved: quantum_of(cand_level + 2'd1, q1_reg, q2_reg)};
                        run_valid_next          = 1'b0;
                        result_next.event_code  = tfq_pkg::EV_DEMOTED;
                        result_next.event_level = cand_level + 2'd1;
                    end
                end
            end
        end
    end

    // pointer and count updates
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
            push_ok[l]    = push_en && (push_lvl == 2'(l))
                            && (count_reg[l] < CNT_W'(MAX_TASKS));
            if (pop_en && pop_lvl == 2'(l))
            begin
                head_next[l]  = wrap_next(head_reg[l]);
                count_next[l] = count_next[l] - 1'b1;
            end
            if (push_ok[l])
            begin
                tail_next[l]  = wrap_next(tail_reg[l]);
                count_next[l] = count_next[l] + 1'b1;
            end
            bypass_sel_next[l] = push_ok[l] && (tail_reg[l] == head_next[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_reg            <= tfq_pkg::Q1_RESET;
            q2_reg            <= tfq_pkg::Q2_RESET;
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            bypass_sel_reg    <= '0;
            run_valid_reg     <= 1'b0;
            run_task_reg      <= 4'd0;
            run_level_reg     <= tfq_pkg::LVL1;
            slice_reg         <= 8'd0;
            time_reg          <= 32'd0;
            present_reg       <= '0;
            state_reg         <= ST_IDLE;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            q1_reg            <= q1_next;
            q2_reg            <= q2_next;
            for (int l = 0; l < 3; l++)
            begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
            bypass_sel_reg    <= bypass_sel_next;
            run_valid_reg     <= run_valid_next;
            run_task_reg      <= run_task_next;
            run_level_reg     <= run_level_next;
            slice_reg         <= slice_next;
            time_reg          <= time_next;
            present_reg       <= present_next;
            state_reg         <= state_next;
            result_strobe_reg <= result_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            bypass_data_reg[l] <= push_entry;
        end
        run_rem_reg  <= run_rem_next;
        run_keep_reg <= run_keep_next;
        run_mod3_reg <= run_mod3_next;
        result_reg   <= result_next;
    end

    // busy from a pre-empting tick always drops in the cycle after it rises
    a_run2_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // while busy, the result on the ports is the pre-emption, never the last item
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> result_strobe && !result.last_of_tick
                 && (result.event_code == tfq_pkg::EV_REQUEUED
                     || result.event_code == tfq_pkg::EV_PROMOTED))
        else $error("unexpected result during pre-emption cycle");

    // a running task is always marked present
    a_running_present: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> present_reg[run_idx])
        else $error("running task not marked present");

    // with unique tasks no push ever finds its FIFO full
    a_no_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (push_ok != 3'b000))
        else $error("push dropped on a full FIFO");

    // a pop only happens on a non-empty level
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |-> any_ready && !run_valid_reg)
        else $error("pop from empty level or while running");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for three_level_feedback_queue_scheduler
// Walks a short directed table, then runs random arrive/tick traffic under
// several quantum settings and sender idle rates. Every result is checked
// field by field, oldest first, against a local model or a typed table row.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_LEVELS   = 3;
    localparam int MAX_TASKS    = 16;
    localparam int RAND_ITEMS   = 1900;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_DIRECTED = 22;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        tfq_pkg::tfq_in_t item;
        logic             typed;
        logic [2:0]       code;
        logic [3:0]       tsk;
        logic [1:0]       lvl;
    } dir_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    tfq_pkg::tfq_in_t               cmd;
    logic                           result_strobe;
    tfq_pkg::tfq_out_t              result;
    logic                           wr_en;
    logic [tfq_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [tfq_pkg::CFG_DATA_W-1:0] wr_data;

    three_level_feedback_queue_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // scheduler model state
    logic [3:0]  q_mem  [NUM_LEVELS][MAX_TASKS];
    logic [3:0]  q_head [NUM_LEVELS];
    logic [3:0]  q_tail [NUM_LEVELS];
    logic [4:0]  q_cnt  [NUM_LEVELS];
    logic [15:0] task_left  [MAX_TASKS];
    logic        task_keep  [MAX_TASKS];
    logic [1:0]  task_pre   [MAX_TASKS];
    logic [7:0]  task_slice [MAX_TASKS];
    logic        run_v;
    logic [3:0]  run_t;
    logic [1:0]  run_l;
    logic [7:0]  slice_left;
    logic [31:0] sched_time;
    logic [7:0]  cfg_q1;
    logic [7:0]  cfg_q2;

    tfq_pkg::tfq_out_t pending_events [$];
    tfq_pkg::tfq_out_t step_res [2];
    int                step_n;
    logic              step_took;
    int                mismatches;
    int                idle_pct;
    dir_row_t          dir_rows [NUM_DIRECTED];
    tfq_pkg::tfq_out_t want;

    function automatic logic [7:0] quantum_for(input logic [1:0] lv);
        logic [7:0] q;
        if (lv == tfq_pkg::LVL3)
            return 8'd0;
        q = (lv == tfq_pkg::LVL1) ? cfg_q1 : cfg_q2;
        return (q == 8'd0) ? 8'd1 : q;
    endfunction

    function automatic void fifo_push(input int l, input logic [3:0] t);
        if (q_cnt[l] < MAX_TASKS)
        begin
            q_mem[l][q_tail[l]] = t;
            q_tail[l] = q_tail[l] + 4'd1;
            q_cnt[l] = q_cnt[l] + 5'd1;
        end
    endfunction

    function automatic logic [3:0] fifo_pop(input int l);
        logic [3:0] t;
        t = q_mem[l][q_head[l]];
        q_head[l] = q_head[l] + 4'd1;
        q_cnt[l] = q_cnt[l] - 5'd1;
        return t;
    endfunction

    function automatic logic task_present(input logic [3:0] t);
        logic [3:0] idx;
        if (run_v && run_t == t)
            return 1'b1;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            idx = q_head[l];
            for (int k = 0; k < q_cnt[l]; k++)
            begin
                if (q_mem[l][idx] == t)
                    return 1'b1;
                idx = idx + 4'd1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void enter_level(input logic [3:0] t, input logic [1:0] lv);
        task_slice[t] = quantum_for(lv);
        fifo_push(int'(lv) - 1, t);
    endfunction

    function automatic void add_event(input logic [2:0] code, input logic [3:0] t,
                                      input logic [1:0] lv);
        step_res[step_n] = '{code, t, lv, sched_time, 1'b0};
        step_n++;
    endfunction

    function automatic void sched_reset();
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            q_head[l] = '0;
            q_tail[l] = '0;
            q_cnt[l]  = '0;
            for (int k = 0; k < MAX_TASKS; k++)
                q_mem[l][k] = '0;
        end
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            task_left[k]  = '0;
            task_keep[k]  = 1'b0;
            task_pre[k]   = '0;
            task_slice[k] = '0;
        end
        run_v      = 1'b0;
        run_t      = '0;
        run_l      = tfq_pkg::LVL1;
        slice_left = '0;
        sched_time = '0;
        cfg_q1     = tfq_pkg::Q1_RESET;
        cfg_q2     = tfq_pkg::Q2_RESET;
    endfunction

    // advance the model by one item; results land in step_res[0..step_n-1]
    function automatic void sched_step(input tfq_pkg::tfq_in_t it);
        logic [3:0] t;
        logic [1:0] lv;
        logic [1:0] m;
        int         l;
        step_n    = 0;
        step_took = 1'b0;
        if (it.opcode == tfq_pkg::OP_ARRIVE)
        begin
            if (it.burst_length == '0 || task_present(it.task_id))
                return;
            t = it.task_id;
            task_left[t] = it.burst_length;
            task_keep[t] = it.keep_leftover;
            task_pre[t]  = '0;
            enter_level(t, tfq_pkg::LVL1);
            step_took = 1'b1;
            return;
        end
        step_took  = 1'b1;
        sched_time = sched_time + 32'd1;

        // lower-level task loses the cpu to a waiting level 1 task
        if (run_v && run_l != tfq_pkg::LVL1 && q_cnt[0] != '0)
        begin
            t = run_t;
            lv = run_l;
            m = (task_pre[t] == tfq_pkg::PREEMPT_LAST) ? 2'd0 : task_pre[t] + 2'd1;
            task_pre[t] = m;
            if (m == 2'd0)
            begin
                enter_level(t, lv - 2'd1);
                add_event(tfq_pkg::EV_PROMOTED, t, lv - 2'd1);
            end
            else
            begin
                task_slice[t] = task_keep[t] ? slice_left : quantum_for(lv);
                fifo_push(int'(lv) - 1, t);
                add_event(tfq_pkg::EV_REQUEUED, t, lv);
            end
            run_v = 1'b0;
        end

        if (!run_v)
        begin
            l = 0;
            while (l < NUM_LEVELS && q_cnt[l] == '0)
                l++;
            if (l == NUM_LEVELS)
            begin
                add_event(tfq_pkg::EV_IDLE, 4'd0, tfq_pkg::LVL1);
                step_res[0].last_of_tick = 1'b1;
                return;
            end
            run_t = fifo_pop(l);
            run_l = 2'(l + 1);
            run_v = 1'b1;
            slice_left = task_keep[run_t] ? task_slice[run_t] : quantum_for(run_l);
            if (slice_left == '0 && run_l != tfq_pkg::LVL3)
                slice_left = 8'd1;
        end

        t = run_t;
        lv = run_l;
        task_left[t] = task_left[t] - 16'd1;
        if (task_left[t] == '0)
        begin
            add_event(tfq_pkg::EV_FINISHED, t, lv);
            run_v = 1'b0;
        end
        else if (lv != tfq_pkg::LVL3)
        begin
            slice_left = slice_left - 8'd1;
            if (slice_left == '0)
            begin
                enter_level(t, lv + 2'd1);
                add_event(tfq_pkg::EV_DEMOTED, t, lv + 2'd1);
                run_v = 1'b0;
            end
            else
                add_event(tfq_pkg::EV_RAN, t, lv);
        end
        else
            add_event(tfq_pkg::EV_RAN, t, lv);
        step_res[step_n-1].last_of_tick = 1'b1;
    endfunction

    function automatic dir_row_t arrive_row(input logic [3:0] id, input logic [15:0] burst,
                                            input logic keep);
        dir_row_t r;
        r = '0;
        r.item = '{tfq_pkg::OP_ARRIVE, id, burst, keep};
        return r;
    endfunction

    function automatic dir_row_t tick_row();
        dir_row_t r;
        r = '0;
        r.item.opcode = tfq_pkg::OP_TICK;
        return r;
    endfunction

    function automatic dir_row_t tick_typed(input logic [2:0] code, input logic [3:0] t,
                                            input logic [1:0] lv);
        dir_row_t r;
        r = tick_row();
        r.typed = 1'b1;
        r.code  = code;
        r.tsk   = t;
        r.lvl   = lv;
        return r;
    endfunction

    function automatic tfq_pkg::tfq_in_t random_item();
        tfq_pkg::tfq_in_t it;
        int               r;
        it = tfq_pkg::tfq_in_t'($bits(tfq_pkg::tfq_in_t)'($urandom));
        r = $urandom_range(99);
        if (r < 14)
        begin
            it.opcode = tfq_pkg::OP_ARRIVE;
            if ($urandom_range(99) == 0)
                it.burst_length = 16'($urandom_range(1, 65535));
            else
                it.burst_length = 16'($urandom_range(1, 12));
        end
        else if (r < 18)
        begin
            // noise: duplicate task or zero burst, both ignored
            it.opcode = tfq_pkg::OP_ARRIVE;
            if (!task_present(it.task_id))
                it.burst_length = '0;
        end
        else
            it.opcode = tfq_pkg::OP_TICK;
        return it;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, exp_val);
    endtask

    task automatic log_expected();
        for (int k = 0; k < step_n; k++)
            pending_events.push_back(step_res[k]);
    endtask

    task automatic send_item(input tfq_pkg::tfq_in_t it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        cmd   <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_idle();
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_quanta(input logic [7:0] q1, input logic [7:0] q2);
        wr_en    <= 1'b1;
        wr_index <= tfq_pkg::REG_Q1;
        wr_data  <= q1;
        @(posedge clk);
        wr_index <= tfq_pkg::REG_Q2;
        wr_data  <= q2;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_q1 = q1;
        cfg_q2 = q2;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_events.size() == 0)
                flag_mismatch("result with none pending", result.event_code, 0);
            else
            begin
                want = pending_events.pop_front();
                if (result.event_code !== want.event_code)
                    flag_mismatch("event_code", result.event_code, want.event_code);
                if (result.event_task !== want.event_task)
                    flag_mismatch("event_task", result.event_task, want.event_task);
                if (result.event_level !== want.event_level)
                    flag_mismatch("event_level", result.event_level, want.event_level);
                if (result.tick_time !== want.tick_time)
                    flag_mismatch("tick_time", result.tick_time, want.tick_time);
                if (result.last_of_tick !== want.last_of_tick)
                    flag_mismatch("last_of_tick", result.last_of_tick, want.last_of_tick);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAIL three_level_feedback_queue_scheduler");
        $finish;
    end

    initial
    begin
        int               phase_q1 [NUM_PHASES];
        int               phase_q2 [NUM_PHASES];
        int               phase_idle [NUM_PHASES];
        int               took;
        tfq_pkg::tfq_in_t it;

        start      = 1'b0;
        cmd        = '0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        rst_n      = 1'b0;
        idle_pct   = 0;
        mismatches = 0;
        sched_reset();

        phase_q1   = '{1, 255, 0, 1, 255, 1};
        phase_q2   = '{1, 255, 0, 1, 1, 255};
        phase_idle = '{0, 72, 33, 0, 72, 33};
        phase_q1[3] = $urandom_range(1, 255);
        phase_q2[3] = $urandom_range(1, 255);
        phase_q2[5] = $urandom_range(0, 255);

        // typed rows run at the reset quanta: level 1 slice 2, level 2 slice 4
        dir_rows = '{
            tick_typed(tfq_pkg::EV_IDLE, 4'd0, tfq_pkg::LVL1),
            arrive_row(4'd0, 16'd0, 1'b0),
            tick_typed(tfq_pkg::EV_IDLE, 4'd0, tfq_pkg::LVL1),
            arrive_row(4'd15, 16'hFFFF, 1'b1),
            arrive_row(4'd15, 16'd3, 1'b0),
            tick_typed(tfq_pkg::EV_RAN, 4'd15, tfq_pkg::LVL1),
            tick_typed(tfq_pkg::EV_DEMOTED, 4'd15, tfq_pkg::LVL2),
            tick_typed(tfq_pkg::EV_RAN, 4'd15, tfq_pkg::LVL2),
            arrive_row(4'd1, 16'd1, 1'b0),
            tick_row(),
            tick_row(),
            tick_row(),
            tick_row(),
            tick_row(),
            arrive_row(4'd2, 16'd1, 1'b1),
            tick_row(),
            tick_row(),
            arrive_row(4'd3, 16'd1, 1'b0),
            tick_row(),
            tick_row(),
            arrive_row(4'd0, 16'd1, 1'b0),
            tick_row()
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_item(dir_rows[i].item);
            sched_step(dir_rows[i].item);
            if (dir_rows[i].typed)
                pending_events.push_back('{dir_rows[i].code, dir_rows[i].tsk,
                                           dir_rows[i].lvl, sched_time, 1'b1});
            else
                log_expected();
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_idle();
            set_quanta(8'(phase_q1[p]), 8'(phase_q2[p]));
            idle_pct = phase_idle[p];
            took = 0;
            while (took < RAND_ITEMS / NUM_PHASES)
            begin
                it = random_item();
                send_item(it);
                sched_step(it);
                log_expected();
                if (step_took)
                    took++;
            end
        end

        drain_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS three_level_feedback_queue_scheduler");
        else
            $display("FAIL three_level_feedback_queue_scheduler");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tfq_pkg.sv
src/tfq_ram.sv
src/three_level_feedback_queue_scheduler.sv
tb/testbench.sv
